@@ rtl/im2col_pkg.sv @@
package im2col_pkg;

  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int MAX_DIM_DEF      = 256;
  localparam int MAX_KERNEL_DEF   = 16;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int DIM_W       = 9;
  localparam int KER_W       = 5;
  localparam int PAD_W       = 4;
  localparam int OUTDIM_W    = 10;
  localparam int CHCNT_W     = 11;
  localparam int SRC_W       = 28;
  localparam int COLIDX_W    = 36;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd7;

  // input kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic start;
    logic step;
    logic mul_a;
    logic mul_b;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic out_free;
  } dp_status_t;

  // zero acts as one, oversize saturates
  function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // counter at or past its limit minus one
  function automatic logic at_end(input logic [31:0] idx, input logic [31:0] limit);
    return ({1'b0, idx} + 33'd1) >= {1'b0, limit};
  endfunction

endpackage

@@ rtl/im2col_ctrl.sv @@
module im2col_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_kind,
  output logic                   in_tready,
  input  im2col_pkg::dp_status_t status,
  output im2col_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL_A = 4'b0010,
    S_MUL_B = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == im2col_pkg::KIND_START) begin
            cmd.start = 1'b1;
          end else if (status.active) begin
            cmd.step  = 1'b1;
            state_nxt = S_MUL_A;
          end
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait here until the output register can take the result
        if (status.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/im2col_datapath.sv @@
module im2col_datapath #(
  parameter int MAX_CHANNELS = im2col_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_DIM      = im2col_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL   = im2col_pkg::MAX_KERNEL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [im2col_pkg::CHCNT_W-1:0]      channel_count,
  input  im2col_pkg::ctrl_cmd_t               cmd,
  output im2col_pkg::dp_status_t              status,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [im2col_pkg::SRC_W-1:0]        out_source_address,
  output logic                                out_is_padding,
  output logic [im2col_pkg::COLIDX_W-1:0]     out_col_index,
  output logic                                out_last
);

  localparam int CIDXW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KIDXW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int OIDXW = $clog2(2 * MAX_DIM);
  localparam int IDXMX = (OIDXW > KIDXW) ? OIDXW : KIDXW;
  localparam int ROWW  = ((IDXMX > im2col_pkg::DIM_W) ? IDXMX : im2col_pkg::DIM_W) + 2;
  localparam int P1W   = CIDXW + im2col_pkg::DIM_W;
  localparam int P2W   = P1W + 1 + im2col_pkg::DIM_W;
  localparam logic [31:0] LIM_CH  = 32'(MAX_CHANNELS);
  localparam logic [31:0] LIM_DIM = 32'(MAX_DIM);
  localparam logic [31:0] LIM_OUT = 32'(2 * MAX_DIM);
  localparam logic [31:0] LIM_KER = 32'(MAX_KERNEL);

  logic [im2col_pkg::DIM_W-1:0]    in_height_r, in_width_r;
  logic [im2col_pkg::KER_W-1:0]    kernel_height_r, kernel_width_r;
  logic [im2col_pkg::PAD_W-1:0]    pad_height_r, pad_width_r;
  logic [im2col_pkg::OUTDIM_W-1:0] out_height_r, out_width_r;

  logic                            active_r;
  logic [im2col_pkg::CHCNT_W-1:0]  channels_total_r;
  logic [CIDXW-1:0]                chan_idx_r;
  logic [KIDXW-1:0]                krow_idx_r, kcol_idx_r;
  logic [OIDXW-1:0]                orow_idx_r, ocol_idx_r;
  logic [im2col_pkg::COLIDX_W-1:0] emitted_count_r;

  logic [im2col_pkg::DIM_W-1:0]    st_row_r, st_col_r;
  logic [CIDXW-1:0]                st_chan_r;
  logic                            st_pad_r, st_last_r;
  logic [im2col_pkg::COLIDX_W-1:0] st_colidx_r;
  logic [P1W-1:0]                  prod1_r;
  logic [P2W-1:0]                  prod2_r;

  logic                            out_valid_r;
  logic [im2col_pkg::SRC_W-1:0]    out_src_r;
  logic                            out_pad_r, out_last_r;
  logic [im2col_pkg::COLIDX_W-1:0] out_colidx_r;

  logic [im2col_pkg::DIM_W-1:0]    ih, iw;
  logic [im2col_pkg::KER_W-1:0]    kh, kw;
  logic [im2col_pkg::OUTDIM_W-1:0] oh, ow;
  logic [im2col_pkg::CHCNT_W-1:0]  ch;
  logic signed [ROWW-1:0]          row_s, col_s;
  logic                            pad, last;
  logic                            end_ocol, end_orow, end_kcol, end_krow, end_chan;
  logic [P1W:0]                    rowsum;
  logic [P2W:0]                    srcsum;

  always_comb begin
    ih = im2col_pkg::DIM_W'(im2col_pkg::clamp_size(32'(in_height_r), LIM_DIM));
    iw = im2col_pkg::DIM_W'(im2col_pkg::clamp_size(32'(in_width_r), LIM_DIM));
    kh = im2col_pkg::KER_W'(im2col_pkg::clamp_size(32'(kernel_height_r), LIM_KER));
    kw = im2col_pkg::KER_W'(im2col_pkg::clamp_size(32'(kernel_width_r), LIM_KER));
    oh = im2col_pkg::OUTDIM_W'(im2col_pkg::clamp_size(32'(out_height_r), LIM_OUT));
    ow = im2col_pkg::OUTDIM_W'(im2col_pkg::clamp_size(32'(out_width_r), LIM_OUT));
    ch = im2col_pkg::CHCNT_W'(im2col_pkg::clamp_size(32'(channels_total_r), LIM_CH));

    row_s = $signed(ROWW'(orow_idx_r)) + $signed(ROWW'(krow_idx_r))
          - $signed(ROWW'(pad_height_r));
    col_s = $signed(ROWW'(ocol_idx_r)) + $signed(ROWW'(kcol_idx_r))
          - $signed(ROWW'(pad_width_r));
    pad = (row_s < 0) || (row_s >= $signed(ROWW'(ih)))
       || (col_s < 0) || (col_s >= $signed(ROWW'(iw)));

    end_ocol = im2col_pkg::at_end(32'(ocol_idx_r), 32'(ow));
    end_orow = im2col_pkg::at_end(32'(orow_idx_r), 32'(oh));
    end_kcol = im2col_pkg::at_end(32'(kcol_idx_r), 32'(kw));
    end_krow = im2col_pkg::at_end(32'(krow_idx_r), 32'(kh));
    end_chan = im2col_pkg::at_end(32'(chan_idx_r), 32'(ch));
    last = end_ocol && end_orow && end_kcol && end_krow && end_chan;

    rowsum = (P1W + 1)'(prod1_r) + (P1W + 1)'(st_row_r);
    srcsum = (P2W + 1)'(prod2_r) + (P2W + 1)'(st_col_r);
  end

  assign status.active   = active_r;
  assign status.out_free = !out_valid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r     <= im2col_pkg::DIM_W'(1);
      in_width_r      <= im2col_pkg::DIM_W'(1);
      kernel_height_r <= im2col_pkg::KER_W'(1);
      kernel_width_r  <= im2col_pkg::KER_W'(1);
      pad_height_r    <= '0;
      pad_width_r     <= '0;
      out_height_r    <= im2col_pkg::OUTDIM_W'(1);
      out_width_r     <= im2col_pkg::OUTDIM_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        im2col_pkg::REG_IN_HEIGHT:     in_height_r     <= cfg_data[im2col_pkg::DIM_W-1:0];
        im2col_pkg::REG_IN_WIDTH:      in_width_r      <= cfg_data[im2col_pkg::DIM_W-1:0];
        im2col_pkg::REG_KERNEL_HEIGHT: kernel_height_r <= cfg_data[im2col_pkg::KER_W-1:0];
        im2col_pkg::REG_KERNEL_WIDTH:  kernel_width_r  <= cfg_data[im2col_pkg::KER_W-1:0];
        im2col_pkg::REG_PAD_HEIGHT:    pad_height_r    <= cfg_data[im2col_pkg::PAD_W-1:0];
        im2col_pkg::REG_PAD_WIDTH:     pad_width_r     <= cfg_data[im2col_pkg::PAD_W-1:0];
        im2col_pkg::REG_OUT_HEIGHT:    out_height_r    <= cfg_data;
        im2col_pkg::REG_OUT_WIDTH:     out_width_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequence counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r         <= 1'b0;
      channels_total_r <= '0;
      chan_idx_r       <= '0;
      krow_idx_r       <= '0;
      kcol_idx_r       <= '0;
      orow_idx_r       <= '0;
      ocol_idx_r       <= '0;
      emitted_count_r  <= '0;
    end else if (cmd.start) begin
      active_r         <= 1'b1;
      channels_total_r <= im2col_pkg::CHCNT_W'(
                            im2col_pkg::clamp_size(32'(channel_count), LIM_CH));
      chan_idx_r       <= '0;
      krow_idx_r       <= '0;
      kcol_idx_r       <= '0;
      orow_idx_r       <= '0;
      ocol_idx_r       <= '0;
      emitted_count_r  <= '0;
    end else if (cmd.step) begin
      emitted_count_r <= emitted_count_r + 1'b1;
      if (last) begin
        active_r <= 1'b0;
      end
      ocol_idx_r <= end_ocol ? '0 : ocol_idx_r + 1'b1;
      if (end_ocol) begin
        orow_idx_r <= end_orow ? '0 : orow_idx_r + 1'b1;
        if (end_orow) begin
          kcol_idx_r <= end_kcol ? '0 : kcol_idx_r + 1'b1;
          if (end_kcol) begin
            krow_idx_r <= end_krow ? '0 : krow_idx_r + 1'b1;
            if (end_krow) begin
              chan_idx_r <= end_chan ? '0 : chan_idx_r + 1'b1;
            end
          end
        end
      end
    end
  end

  // address arithmetic, one multiply per cycle; padding forces every term to zero
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      st_pad_r    <= pad;
      st_last_r   <= last;
      st_colidx_r <= emitted_count_r;
      st_row_r    <= pad ? '0 : row_s[im2col_pkg::DIM_W-1:0];
      st_col_r    <= pad ? '0 : col_s[im2col_pkg::DIM_W-1:0];
      st_chan_r   <= pad ? '0 : chan_idx_r;
    end
    if (cmd.mul_a) begin
      prod1_r <= P1W'(st_chan_r) * P1W'(ih);
    end
    if (cmd.mul_b) begin
      prod2_r <= P2W'(rowsum) * P2W'(iw);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_src_r    <= im2col_pkg::SRC_W'(srcsum);
      out_pad_r    <= st_pad_r;
      out_colidx_r <= st_colidx_r;
      out_last_r   <= st_last_r;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_source_address = out_src_r;
  assign out_is_padding     = out_pad_r;
  assign out_col_index      = out_colidx_r;
  assign out_last           = out_last_r;

endmodule

@@ rtl/im2col_address_generator.sv @@
// channel | direction | handshake           | payload
// in_     | slave     | in_tvalid/in_tready   | tdata: channel_count, tuser: kind
// out_    | master    | out_tvalid/out_tready | tdata: source_address, col_index;
//         |           |                       | tuser: is_padding, tlast: last
// cfg_    | slave     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// a step transaction passes through accept, channel times height multiply,
// row times width multiply, then the final add into the output register.
// a start transaction is complete once accepted; a step while idle is dropped.
// reset is synchronous and active low; no clearing pass is needed.
// a stalled output holds the sequencer in its load state; cfg_ready is always high.
module im2col_address_generator #(
  parameter int MAX_CHANNELS = im2col_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_DIM      = im2col_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL   = im2col_pkg::MAX_KERNEL_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [im2col_pkg::IN_TDATA_W-1:0]    in_tdata,   // [10:0] channel_count
  input  logic                                 in_tuser,   // [0] kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [im2col_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [27:0] source_address, [63:28] col_index
  output logic                                 out_tuser,  // [0] is_padding
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [im2col_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]    cfg_data
);

  im2col_pkg::ctrl_cmd_t           cmd;
  im2col_pkg::dp_status_t          status;
  logic [im2col_pkg::SRC_W-1:0]    source_address;
  logic [im2col_pkg::COLIDX_W-1:0] col_index;

  assign cfg_ready = 1'b1;

  im2col_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  im2col_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_DIM      (MAX_DIM),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .channel_count      (in_tdata[im2col_pkg::CHCNT_W-1:0]),
    .cmd                (cmd),
    .status             (status),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_source_address (source_address),
    .out_is_padding     (out_tuser),
    .out_col_index      (col_index),
    .out_last           (out_tlast)
  );

  assign out_tdata = {col_index, source_address};

endmodule

@@ rtl/im2col_checker.sv @@
module im2col_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [im2col_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                                in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [im2col_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                                out_tuser,
  input logic                                out_tlast
);

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("stalled output changed");

  // padding elements carry a zero source address
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[im2col_pkg::SRC_W-1:0] == '0)
    else $error("padding element with nonzero address");

  // after a start transaction is taken, the input is ready again in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == im2col_pkg::KIND_START) |=> in_tready)
    else $error("start did not return to ready");

  // a start transaction produces no result of its own
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == im2col_pkg::KIND_START) && !out_tvalid
    |=> !out_tvalid)
    else $error("start produced a result");

endmodule

bind im2col_address_generator im2col_checker u_im2col_checker (.*);
